// ===== hdl/bfie_pkg.sv =====
// bfie_pkg: shared constants for the instruction executor.
// Character codes, field widths and default sizes; no dependencies.

package bfie_pkg;

    // field widths fixed by the channel payloads
    localparam int CHAR_W = 8;
    localparam int POS_W  = 16;
    localparam int NEST_W = 16;

    // default sizes handed to the top level
    localparam int DEF_CELL_COUNT  = 128;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_POS_BITS    = 16;

    // nesting counter saturates here while skipping
    localparam logic [NEST_W-1:0] NEST_MAX = '1;

    // program characters that act
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h3E;  // '>'
    localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h3C;  // '<'
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;  // ']'

endpackage

// ===== hdl/bfie_cmd_if.sv =====
// bfie_cmd_if: request channel carrying one program character per request.
// Depends on bfie_pkg for field widths.

interface bfie_cmd_if;
    import bfie_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] instr;
    logic [POS_W-1:0]  next_pos;
    logic [CHAR_W-1:0] key;

    modport source (output valid, output instr, output next_pos, output key, input ready);
    modport sink   (input valid, input instr, input next_pos, input key, output ready);
endinterface

// ===== hdl/bfie_res_if.sv =====
// bfie_res_if: result channel, one result request per executed character.
// Depends on bfie_pkg for field widths.

interface bfie_res_if;
    import bfie_pkg::*;

    logic              valid;
    logic              ready;
    logic              out_valid;
    logic [CHAR_W-1:0] out_byte;
    logic              jump;
    logic [POS_W-1:0]  jump_target;
    logic              skipping;
    logic              stack_overflow;

    modport source (output valid, output out_valid, output out_byte, output jump,
                    output jump_target, output skipping, output stack_overflow,
                    input ready);
    modport sink   (input valid, input out_valid, input out_byte, input jump,
                    input jump_target, input skipping, input stack_overflow,
                    output ready);
endinterface

// ===== hdl/bfie_ram.sv =====
// bfie_ram: generic simple dual-port RAM, one write and one registered read.
// Read returns the old contents on a same-address write. No dependencies.

module bfie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/bf_instruction_executor.sv =====
// bf_instruction_executor: top level of the character executor.
// Depends on bfie_pkg, bfie_cmd_if, bfie_res_if and bfie_ram.
//
//  channel | dir | payload                                           | handshake
//  --------+-----+---------------------------------------------------+-----------
//  cmd     | in  | instr, next_pos, key                              | valid/ready
//  res     | out | out_valid, out_byte, jump, jump_target, skipping, | valid/ready
//          |     | stack_overflow                                    |
//
// One character per cycle while res accepts and no clearing pass runs; each request
// passes the input register, then the result register. The current cell and both neighbours sit
// in registers; a pointer move refills one neighbour from the tape RAM read port.
// After reset a clearing pass zeroes every tape RAM cell with cmd.ready low.
// A stalled res side holds one result and one queued request, then drops cmd.ready.

module bf_instruction_executor #(
    parameter int CELL_COUNT  = bfie_pkg::DEF_CELL_COUNT,
    parameter int STACK_DEPTH = bfie_pkg::DEF_STACK_DEPTH,
    parameter int POS_BITS    = bfie_pkg::DEF_POS_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    bfie_cmd_if.sink  cmd,
    bfie_res_if.source res
);
    import bfie_pkg::*;

    localparam int DP_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SC_W = $clog2(STACK_DEPTH + 1);
    localparam logic [DP_W-1:0] LAST_DP   = DP_W'(CELL_COUNT - 1);
    localparam logic [SC_W-1:0] FULL_CNT  = SC_W'(STACK_DEPTH);
    localparam bit              TWO_CELLS = (CELL_COUNT == 2);

    function automatic logic [DP_W-1:0] dp_inc(input logic [DP_W-1:0] a);
        logic [DP_W-1:0] r;
        r = (a == LAST_DP) ? '0 : a + 1'b1;
        return r;
    endfunction

    function automatic logic [DP_W-1:0] dp_dec(input logic [DP_W-1:0] a);
        logic [DP_W-1:0] r;
        r = (a == '0) ? LAST_DP : a - 1'b1;
        return r;
    endfunction

    // input register
    logic              q_valid_reg;
    logic [CHAR_W-1:0] q_instr_reg;
    logic [POS_W-1:0]  q_next_pos_reg;
    logic [CHAR_W-1:0] q_key_reg;

    // result register
    logic              r_valid_reg;
    logic              r_ov_reg, r_jmp_reg, r_skip_reg, r_sof_reg;
    logic [CHAR_W-1:0] r_ob_reg;
    logic [POS_W-1:0]  r_jt_reg;

    // clearing pass
    logic              clr_active_reg;
    logic [DP_W-1:0]   clr_addr_reg;

    // tape window: current cell and its neighbours
    logic [DP_W-1:0]   dp_reg, dp_next;
    logic [CHAR_W-1:0] cur_reg, cur_next;
    logic [CHAR_W-1:0] left_reg, left_next, right_reg, right_next;
    logic              left_pend_reg, left_pend_next, right_pend_reg, right_pend_next;
    logic              byp_reg, byp_next;
    logic [CHAR_W-1:0] byp_data_reg;
    logic [CHAR_W-1:0] rd_eff, left_eff, right_eff;
    logic [DP_W-1:0]   dp_p1, dp_p2, dp_m1, dp_m2;

    // tape RAM ports
    logic              tape_we, ex_we, tape_re;
    logic [DP_W-1:0]   tape_waddr, ex_waddr, tape_raddr;
    logic [CHAR_W-1:0] tape_wdata, ex_wdata, tape_rdata;

    // loop stack
    logic [SC_W-1:0]     cnt_reg, cnt_next;
    logic [POS_BITS-1:0] tos_reg, tos_next, tos_eff;
    logic                tos_pend_reg, tos_pend_next;
    logic                stk_we, stk_re;
    logic [SA_W-1:0]     stk_waddr, stk_raddr;
    logic [POS_BITS-1:0] stk_wdata, stk_rdata, npos;
    logic [SC_W:0]       cnt_m2;
    logic                cnt_ge2;

    // skip mode
    logic              skip_reg, skip_next;
    logic [NEST_W-1:0] nest_reg, nest_next;

    // result of the executing character
    logic              ex_ov, ex_jmp, ex_sof;
    logic [CHAR_W-1:0] ex_ob;
    logic [POS_W-1:0]  ex_jt;

    logic exec_fire, cmd_fire, cell_nz;

    // handshakes
    assign exec_fire = q_valid_reg && (!r_valid_reg || res.ready);
    assign cmd.ready = !clr_active_reg && (!q_valid_reg || exec_fire);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // neighbour addresses, wrapping at the tape ends
    assign dp_p1 = dp_inc(dp_reg);
    assign dp_p2 = dp_inc(dp_p1);
    assign dp_m1 = dp_dec(dp_reg);
    assign dp_m2 = dp_dec(dp_m1);

    // a neighbour refilled last cycle comes from the read port, or from the bypass on a same-address write
    assign rd_eff    = byp_reg ? byp_data_reg : tape_rdata;
    assign left_eff  = left_pend_reg  ? rd_eff : left_reg;
    assign right_eff = right_pend_reg ? rd_eff : right_reg;
    assign tos_eff   = tos_pend_reg   ? stk_rdata : tos_reg;
    assign cell_nz   = (cur_reg != '0);

    assign npos    = POS_BITS'(q_next_pos_reg);
    assign cnt_m2  = {1'b0, cnt_reg} - (SC_W+1)'(2);
    assign cnt_ge2 = ({1'b0, cnt_reg} >= (SC_W+1)'(2));

    // execute one character
    always_comb
    begin
        dp_next         = dp_reg;
        cur_next        = cur_reg;
        left_next       = left_eff;
        right_next      = right_eff;
        left_pend_next  = 1'b0;
        right_pend_next = 1'b0;
        ex_we           = 1'b0;
        ex_waddr        = dp_m1;
        ex_wdata        = left_eff;
        tape_re         = 1'b0;
        tape_raddr      = dp_p2;
        cnt_next        = cnt_reg;
        tos_next        = tos_eff;
        tos_pend_next   = 1'b0;
        stk_we          = 1'b0;
        stk_waddr       = cnt_reg[SA_W-1:0];
        stk_wdata       = npos;
        stk_re          = 1'b0;
        stk_raddr       = cnt_m2[SA_W-1:0];
        skip_next       = skip_reg;
        nest_next       = nest_reg;
        ex_ov           = 1'b0;
        ex_ob           = '0;
        ex_jmp          = 1'b0;
        ex_jt           = '0;
        ex_sof          = 1'b0;
        if (exec_fire)
        begin
            if (skip_reg)
            begin
                // only brackets count while skipping
                if (q_instr_reg == CH_OPEN)
                begin
                    if (nest_reg != NEST_MAX)
                    begin
                        nest_next = nest_reg + 1'b1;
                    end
                end
                else if (q_instr_reg == CH_CLOSE)
                begin
                    if (nest_reg != '0)
                    begin
                        nest_next = nest_reg - 1'b1;
                    end
                    else
                    begin
                        skip_next = 1'b0;
                    end
                end
            end
            else
            begin
                case (q_instr_reg)
                    CH_PLUS:  cur_next = cur_reg + 1'b1;
                    CH_MINUS: cur_next = cur_reg - 1'b1;
                    CH_COMMA: cur_next = q_key_reg;
                    CH_DOT:
                    begin
                        ex_ov = 1'b1;
                        ex_ob = cur_reg;
                    end
                    CH_RIGHT:
                    begin
                        // shift window up; left cell retires to RAM
                        dp_next   = dp_p1;
                        cur_next  = right_eff;
                        left_next = cur_reg;
                        if (TWO_CELLS)
                        begin
                            right_next = cur_reg;
                        end
                        else
                        begin
                            ex_we           = 1'b1;
                            ex_waddr        = dp_m1;
                            ex_wdata        = left_eff;
                            tape_re         = 1'b1;
                            tape_raddr      = dp_p2;
                            right_pend_next = 1'b1;
                        end
                    end
                    CH_LEFT:
                    begin
                        // shift window down; right cell retires to RAM
                        dp_next    = dp_m1;
                        cur_next   = left_eff;
                        right_next = cur_reg;
                        if (TWO_CELLS)
                        begin
                            left_next = cur_reg;
                        end
                        else
                        begin
                            ex_we          = 1'b1;
                            ex_waddr       = dp_p1;
                            ex_wdata       = right_eff;
                            tape_re        = 1'b1;
                            tape_raddr     = dp_m2;
                            left_pend_next = 1'b1;
                        end
                    end
                    CH_OPEN:
                    begin
                        if (cell_nz)
                        begin
                            if (cnt_reg == FULL_CNT)
                            begin
                                ex_sof = 1'b1;
                            end
                            else
                            begin
                                stk_we   = 1'b1;
                                tos_next = npos;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            skip_next = 1'b1;
                            nest_next = '0;
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (cnt_reg != '0)
                        begin
                            if (cell_nz)
                            begin
                                ex_jmp = 1'b1;
                                ex_jt  = POS_W'(tos_eff);
                            end
                            else
                            begin
                                // pop; fetch the entry below as new top
                                cnt_next = cnt_reg - 1'b1;
                                if (cnt_ge2)
                                begin
                                    stk_re        = 1'b1;
                                    tos_pend_next = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // tape RAM write port shared with the clearing pass
    assign tape_we    = clr_active_reg || ex_we;
    assign tape_waddr = clr_active_reg ? clr_addr_reg : ex_waddr;
    assign tape_wdata = clr_active_reg ? '0 : ex_wdata;
    assign byp_next   = tape_re && tape_we && (tape_waddr == tape_raddr);

    bfie_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELL_COUNT)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .re    (tape_re),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    bfie_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg    <= 1'b0;
            r_valid_reg    <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            dp_reg         <= '0;
            cur_reg        <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            left_pend_reg  <= 1'b0;
            right_pend_reg <= 1'b0;
            byp_reg        <= 1'b0;
            cnt_reg        <= '0;
            tos_pend_reg   <= 1'b0;
            skip_reg       <= 1'b0;
            nest_reg       <= '0;
        end
        else
        begin
            if (cmd_fire)
            begin
                q_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                q_valid_reg <= 1'b0;
            end

            if (exec_fire)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                r_valid_reg <= 1'b0;
            end

            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_DP)
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            dp_reg         <= dp_next;
            cur_reg        <= cur_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            left_pend_reg  <= left_pend_next;
            right_pend_reg <= right_pend_next;
            byp_reg        <= byp_next;
            cnt_reg        <= cnt_next;
            tos_pend_reg   <= tos_pend_next;
            skip_reg       <= skip_next;
            nest_reg       <= nest_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            q_instr_reg    <= cmd.instr;
            q_next_pos_reg <= cmd.next_pos;
            q_key_reg      <= cmd.key;
        end
        if (exec_fire)
        begin
            r_ov_reg   <= ex_ov;
            r_ob_reg   <= ex_ob;
            r_jmp_reg  <= ex_jmp;
            r_jt_reg   <= ex_jt;
            r_skip_reg <= skip_next;
            r_sof_reg  <= ex_sof;
        end
        byp_data_reg <= tape_wdata;
        tos_reg      <= tos_next;
    end

    assign res.valid          = r_valid_reg;
    assign res.out_valid      = r_ov_reg;
    assign res.out_byte       = r_ob_reg;
    assign res.jump           = r_jmp_reg;
    assign res.jump_target    = r_jt_reg;
    assign res.skipping       = r_skip_reg;
    assign res.stack_overflow = r_sof_reg;
endmodule

// ===== hdl/bfie_checker.sv =====
// bfie_checker: port-level checks on the executor's result channel.
// Depends on bfie_pkg; bound to bf_instruction_executor below.

module bfie_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       res_out_valid,
    input logic [bfie_pkg::CHAR_W-1:0] res_out_byte,
    input logic                       res_jump,
    input logic [bfie_pkg::POS_W-1:0] res_jump_target,
    input logic                       res_skipping,
    input logic                       res_stack_overflow
);
    import bfie_pkg::*;

    // an emitted byte never comes with a jump or an overflow
    a_dot_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_out_valid |-> !res_jump && !res_stack_overflow)
        else $error("emit combined with jump or overflow");

    // idle byte and target fields read as zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_out_valid || res_out_byte == '0)
                   && (res_jump || res_jump_target == '0))
        else $error("unused result field not zero");

    // a dropped push happens outside skip mode and gives no jump
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stack_overflow |-> !res_jump && !res_skipping)
        else $error("overflow with jump or skipping");

    // neither a jump nor an emitted byte is reported while skipping
    a_no_skip_jump: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_skipping |-> !res_jump && !res_out_valid)
        else $error("action reported while skipping");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_byte)
                                 && $stable(res_jump_target) && $stable(res_jump))
        else $error("stalled result changed");
endmodule

bind bf_instruction_executor bfie_checker u_bfie_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_out_valid      (res.out_valid),
    .res_out_byte       (res.out_byte),
    .res_jump           (res.jump),
    .res_jump_target    (res.jump_target),
    .res_skipping       (res.skipping),
    .res_stack_overflow (res.stack_overflow)
);

// ===== dv/tb_bf_instruction_executor.sv =====
// tb_bf_instruction_executor: self-checking testbench for the character executor.
// Depends on bfie_pkg, bfie_cmd_if, bfie_res_if and the bf_instruction_executor RTL.
// Drives programs on cmd, predicts each result in order and checks it on res.

module tb_bf_instruction_executor;
    import bfie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS       = DEF_CELL_COUNT;
    localparam int STACKS      = DEF_STACK_DEPTH;
    localparam int POS_BITS    = DEF_POS_BITS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 64;
    localparam logic [POS_W-1:0] POS_MASK = POS_W'((64'd1 << POS_BITS) - 1);

    typedef struct packed {
        logic [CHAR_W-1:0] instr;
        logic [POS_W-1:0]  next_pos;
        logic [CHAR_W-1:0] key;
    } char_req_t;

    typedef struct packed {
        logic              out_valid;
        logic [CHAR_W-1:0] out_byte;
        logic              jump;
        logic [POS_W-1:0]  jump_target;
        logic              skipping;
        logic              stack_overflow;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bfie_cmd_if cmd_bus ();
    bfie_res_if res_bus ();

    bf_instruction_executor #(
        .CELL_COUNT  (CELLS),
        .STACK_DEPTH (STACKS),
        .POS_BITS    (POS_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    // program characters waiting to be offered, outcomes waiting to be seen
    char_req_t program_queue [$];
    outcome_t  expected_outcomes [$];
    char_req_t on_offer;

    // executor state as the predictor sees it
    logic [CHAR_W-1:0] tape_model [CELLS];
    int unsigned       cell_ptr;
    logic [POS_W-1:0]  loop_pos [STACKS];
    int unsigned       loop_count;
    logic              skip_on;
    logic [NEST_W-1:0] nest_lvl;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    bit          hold_armed = 1'b0;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // works out the outcome of one character and advances the state
    function automatic outcome_t execute_char(char_req_t r);
        outcome_t          o;
        logic [CHAR_W-1:0] cur_val;
        logic [POS_W-1:0]  pos;
        o = '0;
        pos = r.next_pos & POS_MASK;
        cur_val = tape_model[cell_ptr];
        if (skip_on)
        begin
            // only brackets count while skipping a loop body
            if (r.instr == CH_OPEN)
            begin
                if (nest_lvl != NEST_MAX)
                    nest_lvl = nest_lvl + 1'b1;
            end
            else if (r.instr == CH_CLOSE)
            begin
                if (nest_lvl != '0)
                    nest_lvl = nest_lvl - 1'b1;
                else
                    skip_on = 1'b0;
            end
        end
        else
        begin
            case (r.instr)
                CH_PLUS:  tape_model[cell_ptr] = cur_val + 1'b1;
                CH_MINUS: tape_model[cell_ptr] = cur_val - 1'b1;
                CH_RIGHT: cell_ptr = (cell_ptr == CELLS - 1) ? 0 : cell_ptr + 1;
                CH_LEFT:  cell_ptr = (cell_ptr == 0) ? CELLS - 1 : cell_ptr - 1;
                CH_DOT:
                begin
                    o.out_valid = 1'b1;
                    o.out_byte  = cur_val;
                end
                CH_COMMA: tape_model[cell_ptr] = r.key;
                CH_OPEN:
                begin
                    if (cur_val != '0)
                    begin
                        if (loop_count < STACKS)
                        begin
                            loop_pos[loop_count] = pos;
                            loop_count++;
                        end
                        else
                            o.stack_overflow = 1'b1;
                    end
                    else
                    begin
                        skip_on  = 1'b1;
                        nest_lvl = '0;
                    end
                end
                CH_CLOSE:
                begin
                    // jump back without popping while the cell is nonzero
                    if (loop_count != 0)
                    begin
                        if (cur_val != '0)
                        begin
                            o.jump        = 1'b1;
                            o.jump_target = loop_pos[loop_count - 1];
                        end
                        else
                            loop_count--;
                    end
                end
                default: ;
            endcase
        end
        o.skipping = skip_on;
        return o;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_key();
        // zero keys are frequent so that loops get skipped as well as entered
        return ($urandom_range(0, 3) == 0) ? '0 : CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic add_char(input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] k);
        char_req_t r;
        r.instr    = ch;
        r.next_pos = POS_W'($urandom_range(0, 65535));
        r.key      = k;
        program_queue.push_back(r);
    endtask

    // balanced program fragment with random content
    task automatic gen_program(input int unsigned len);
        int unsigned open_cnt;
        int unsigned pick;
        open_cnt = 0;
        for (int unsigned i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                add_char(CH_PLUS, rand_key());
            else if (pick < 30)
                add_char(CH_MINUS, rand_key());
            else if (pick < 40)
                add_char(CH_RIGHT, rand_key());
            else if (pick < 50)
                add_char(CH_LEFT, rand_key());
            else if (pick < 62)
                add_char(CH_DOT, rand_key());
            else if (pick < 72)
                add_char(CH_COMMA, rand_key());
            else if (pick < 84)
            begin
                add_char(CH_OPEN, rand_key());
                open_cnt++;
            end
            else if (open_cnt != 0)
            begin
                add_char(CH_CLOSE, rand_key());
                open_cnt--;
            end
            else
                add_char(CH_PLUS, rand_key());
        end
        while (open_cnt != 0)
        begin
            add_char(CH_CLOSE, rand_key());
            open_cnt--;
        end
    endtask

    // arbitrary bytes and stray brackets; closes lean ahead so skipping drains out
    task automatic gen_noise(input int unsigned len);
        int unsigned pick;
        for (int unsigned i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                add_char(CH_OPEN, rand_key());
            else if (pick < 30)
                add_char(CH_CLOSE, rand_key());
            else
                add_char(CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    // nest past the stack depth, take a few jumps, then unwind on a zero cell
    task automatic gen_deep_nest();
        int unsigned depth;
        depth = $urandom_range(STACKS + 1, STACKS + 6);
        add_char(CH_COMMA, CHAR_W'($urandom_range(1, 255)));
        repeat (depth) add_char(CH_OPEN, rand_key());
        repeat ($urandom_range(1, 3)) add_char(CH_CLOSE, rand_key());
        add_char(CH_COMMA, '0);
        repeat (depth) add_char(CH_CLOSE, rand_key());
    endtask

    task automatic fill_random(input int unsigned n);
        int unsigned start_size;
        start_size = program_queue.size();
        gen_deep_nest();
        while (program_queue.size() - start_size < n)
        begin
            if ($urandom_range(0, 99) < 80)
                gen_program($urandom_range(4, 30));
            else
                gen_noise($urandom_range(1, 6));
        end
    endtask

    task automatic wait_drained();
        while (program_queue.size() != 0 || cmd_bus.valid || expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                expected_outcomes.push_back(execute_char(on_offer));
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (program_queue.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    on_offer = program_queue.pop_front();
                    cmd_bus.valid    <= 1'b1;
                    cmd_bus.instr    <= on_offer.instr;
                    cmd_bus.next_pos <= on_offer.next_pos;
                    cmd_bus.key      <= on_offer.key;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started once when armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // result monitor and receiver readiness
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_o;
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result request with no outcome outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_o = expected_outcomes.pop_front();
                    check_field("out_valid", 32'(exp_o.out_valid), 32'(res_bus.out_valid));
                    check_field("out_byte", 32'(exp_o.out_byte), 32'(res_bus.out_byte));
                    check_field("jump", 32'(exp_o.jump), 32'(res_bus.jump));
                    check_field("jump_target", 32'(exp_o.jump_target),
                                32'(res_bus.jump_target));
                    check_field("skipping", 32'(exp_o.skipping), 32'(res_bus.skipping));
                    check_field("stack_overflow", 32'(exp_o.stack_overflow),
                                32'(res_bus.stack_overflow));
                end
            end
            res_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_bf_instruction_executor: FAIL");
            $finish;
        end
    end

    initial
    begin
        cmd_bus.valid    = 1'b0;
        cmd_bus.instr    = '0;
        cmd_bus.next_pos = '0;
        cmd_bus.key      = '0;
        res_bus.ready    = 1'b0;
        for (int i = 0; i < CELLS; i++)
            tape_model[i] = '0;
        for (int i = 0; i < STACKS; i++)
            loop_pos[i] = '0;
        cell_ptr   = 0;
        loop_count = 0;
        skip_on    = 1'b0;
        nest_lvl   = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles now and then, receiver mostly
        send_idle = 29;
        recv_idle = 79;

        // directed: cell and pointer wrap, every operation, bracket corner cases
        add_char(CH_DOT, '0);
        add_char(CH_MINUS, '0);
        add_char(CH_DOT, '0);
        add_char(CH_PLUS, '0);
        add_char(CH_LEFT, '0);
        add_char(CH_COMMA, 8'hFF);
        add_char(CH_DOT, '0);
        add_char(CH_RIGHT, '0);
        add_char(CH_CLOSE, '0);           // zero cell, empty stack
        add_char(CH_PLUS, '0);
        add_char(CH_CLOSE, '0);           // nonzero cell, empty stack
        program_queue.push_back(char_req_t'{instr: CH_OPEN, next_pos: 16'hFFFF, key: 8'h00});
        add_char(CH_CLOSE, '0);           // jump to the all-ones position
        add_char(CH_COMMA, '0);
        add_char(CH_CLOSE, '0);           // pop
        add_char(CH_OPEN, '0);            // zero cell: start skipping
        add_char(CH_PLUS, '0);
        add_char(CH_OPEN, '0);
        add_char(CH_CLOSE, '0);
        add_char(8'h00, 8'hFF);
        add_char(CH_CLOSE, '0);           // matching close ends the skip
        add_char(8'hFF, '0);
        add_char(CH_COMMA, 8'hA5);
        program_queue.push_back(char_req_t'{instr: CH_OPEN, next_pos: 16'h0000, key: 8'hFF});
        add_char(CH_CLOSE, '0);
        fill_random(450);
        wait_drained();

        // receiver idles now and then, sender mostly
        send_idle = 79;
        recv_idle = 29;
        fill_random(450);
        wait_drained();

        // no idling; the receiver stalls for a long stretch at the start
        send_idle  = 0;
        recv_idle  = 0;
        hold_armed = 1'b1;
        fill_random(500);
        wait_drained();

        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("tb_bf_instruction_executor: PASS");
        else
            $display("tb_bf_instruction_executor: FAIL");
        $finish;
    end

endmodule
